/* rtl/relation_property_checker_unit_macros.svh */
// Assertion macros for the relation property checker.
// Used by the checker module; depends on nothing else.
`ifndef RELATION_PROPERTY_CHECKER_UNIT_MACROS_SVH
`define RELATION_PROPERTY_CHECKER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("relation property checker: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("relation property checker: next-cycle check failed");

`endif

/* rtl/rpc_pkg.sv */
// Shared codes for the relation property checker.
// Holds the action codes and the sequencer state type; depends on nothing.
package rpc_pkg;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_SET   = 2'd1;
  localparam logic [1:0] ACT_EVAL  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SET_RD = 5'b00010,
    ST_SET_WR = 5'b00100,
    ST_EVAL   = 5'b01000,
    ST_DRAIN  = 5'b10000
  } state_t;

endpackage

/* rtl/rpc_row_store.sv */
// Row memory of the relation matrix with per-row valid flags.
// One write port, one registered read port; depends on nothing else.
module rpc_row_store #(
  parameter int MAX_ELEMENTS = 16,
  localparam int IDX_W = $clog2(MAX_ELEMENTS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clear_all,
  input  logic                    rd_en,
  input  logic [IDX_W-1:0]        rd_addr,
  output logic [MAX_ELEMENTS-1:0] rd_row,
  input  logic                    wr_en,
  input  logic [IDX_W-1:0]        wr_addr,
  input  logic [MAX_ELEMENTS-1:0] wr_row
);

  logic [MAX_ELEMENTS-1:0] mem [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] row_valid;
  logic [MAX_ELEMENTS-1:0] rd_data;
  logic                    rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= row_valid[rd_addr];
    end
  end

  // A row that was never written since the last clear reads as empty.
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  assign rd_row = rd_valid ? rd_data : '0;

endmodule

/* rtl/relation_property_checker_unit.sv */
// Top level of the relation property checker: command decode, evaluation
// sequencer and result registers. Depends on rpc_pkg and rpc_row_store.
//
//   channel   signals                               transfer when
//   -------   -----------------------------------   ---------------------
//   config    cfg_we, cfg_wdata                     cfg_we high
//   command   start, busy, action, row/col_index    start high, busy low
//   result    done, flags and counts                done high (one cycle)
//
// A clear, or a set of a pair out of range, leaves busy low. Other sets hold busy
// through a read and a write back. An evaluate holds busy through a row walk
// (none when n is zero) and a drain, n being the active element count, one row
// read per cycle, n+1 reads per matrix row; done rises as busy falls. Reset is
// synchronous and the matrix reads as empty after it. Results cannot be held off.
module relation_property_checker_unit
  import rpc_pkg::*;
#(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  input  logic       start,
  input  logic [1:0] action,
  input  logic [3:0] row_index,
  input  logic [3:0] col_index,
  output logic       busy,
  output logic       done,
  output logic       is_reflexive,
  output logic       is_irreflexive,
  output logic       is_symmetric,
  output logic       is_antisymmetric,
  output logic       is_asymmetric,
  output logic       is_transitive,
  output logic       is_equivalence,
  output logic       is_partial_order,
  output logic [4:0] missing_diagonal,
  output logic [7:0] missing_mirror,
  output logic [7:0] antisym_conflicts,
  output logic [8:0] missing_transitive
);

  localparam int IDX_W   = $clog2(MAX_ELEMENTS);
  localparam int POP_W   = $clog2(MAX_ELEMENTS + 1);
  localparam int ACC_RAW = $clog2(MAX_ELEMENTS * MAX_ELEMENTS + 1);
  localparam int ACC_W   = ACC_RAW > 9 ? ACC_RAW : 9;
  localparam int CAP     = MAX_ELEMENTS > 31 ? 31 : MAX_ELEMENTS;

  state_t state;

  logic [4:0]              elem_count;
  logic [4:0]              n;
  logic [IDX_W-1:0]        n_last;
  logic [MAX_ELEMENTS-1:0] size_mask;
  logic [MAX_ELEMENTS-1:0] col_bit;
  logic                    accept;
  logic                    in_range;

  logic [3:0]              row_q;
  logic [3:0]              col_q;

  // Read issue side of the evaluation walk.
  logic [IDX_W-1:0]        x_iss;
  logic [IDX_W-1:0]        y_iss;
  logic                    iss_row;

  // What the read that returns this cycle was for.
  logic                    tag_valid;
  logic                    tag_row;
  logic [IDX_W-1:0]        tag_x;
  logic [IDX_W-1:0]        tag_y;
  logic                    tag_last;

  logic [MAX_ELEMENTS-1:0] rx;
  logic [MAX_ELEMENTS-1:0] reach;
  logic [MAX_ELEMENTS-1:0] reach_next;
  logic [MAX_ELEMENTS-1:0] row_m;
  logic [MAX_ELEMENTS-1:0] pop_vec;
  logic                    pop_valid;
  logic [POP_W-1:0]        pop_cnt;
  logic                    cnt_valid;

  logic [ACC_W-1:0]        acc_diag;
  logic [ACC_W-1:0]        acc_mirror;
  logic [ACC_W-1:0]        acc_conf;
  logic [ACC_W-1:0]        acc_trans;
  logic                    diag_seen;
  logic                    asym;

  logic                    clear_all;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic [MAX_ELEMENTS-1:0] rd_row;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [MAX_ELEMENTS-1:0] wr_row;

  function automatic logic [POP_W-1:0] popcount(input logic [MAX_ELEMENTS-1:0] v);
    logic [POP_W-1:0] c;
    c = '0;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      c = c + POP_W'(v[i]);
    end
    return c;
  endfunction

  rpc_row_store #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .clear_all(clear_all),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_row   (rd_row),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_row   (wr_row)
  );

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign n        = (elem_count > 5'(CAP)) ? 5'(CAP) : elem_count;
  assign n_last   = IDX_W'(n - 5'd1);
  assign in_range = ({1'b0, row_index} < n) && ({1'b0, col_index} < n);

  always_comb begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      size_mask[i] = (i < int'(n));
      col_bit[i]   = (i == int'(col_q));
    end
  end

  assign row_m = rd_row & size_mask;

  assign clear_all = accept && (action == ACT_CLEAR);
  assign rd_en     = (state == ST_SET_RD) || (state == ST_EVAL);
  assign rd_addr   = (state == ST_SET_RD) ? IDX_W'(row_q) : (iss_row ? x_iss : y_iss);
  assign wr_en     = (state == ST_SET_WR);
  assign wr_addr   = IDX_W'(row_q);
  assign wr_row    = rd_row | col_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= 5'd16;
    end else if (cfg_we) begin
      elem_count <= cfg_wdata;
    end
  end

  // Command decode and read issue.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tag_valid <= 1'b0;
    end else begin
      tag_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (action)
              ACT_SET: begin
                if (in_range) begin
                  state <= ST_SET_RD;
                end
              end
              ACT_EVAL: begin
                x_iss   <= '0;
                y_iss   <= '0;
                iss_row <= 1'b1;
                state   <= (n == 5'd0) ? ST_DRAIN : ST_EVAL;
              end
              default: ;
            endcase
          end
        end
        ST_SET_RD: state <= ST_SET_WR;
        ST_SET_WR: state <= ST_IDLE;
        ST_EVAL: begin
          tag_valid <= 1'b1;
          tag_row   <= iss_row;
          tag_x     <= x_iss;
          tag_y     <= y_iss;
          tag_last  <= !iss_row && (y_iss == n_last);
          if (iss_row) begin
            iss_row <= 1'b0;
            y_iss   <= '0;
          end else if (y_iss == n_last) begin
            if (x_iss == n_last) begin
              state <= ST_DRAIN;
            end else begin
              x_iss   <= x_iss + IDX_W'(1);
              iss_row <= 1'b1;
            end
          end else begin
            y_iss <= y_iss + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (!tag_valid && !pop_valid && !cnt_valid) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_q <= row_index;
      col_q <= col_index;
    end
  end

  always_comb begin
    reach_next = reach;
    if (rx[tag_y]) begin
      reach_next = reach | row_m;
    end
  end

  // Evaluation datapath: consumes one returned row per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      pop_valid <= 1'b0;
      cnt_valid <= 1'b0;
    end else begin
      pop_valid <= tag_valid && !tag_row && tag_last;
      cnt_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (action == ACT_EVAL)) begin
      acc_diag   <= '0;
      acc_mirror <= '0;
      acc_conf   <= '0;
      acc_trans  <= '0;
      diag_seen  <= 1'b0;
      asym       <= 1'b1;
    end else begin
      if (tag_valid) begin
        if (tag_row) begin
          rx    <= row_m;
          reach <= '0;
          if (row_m[tag_x]) begin
            diag_seen <= 1'b1;
          end else begin
            acc_diag <= acc_diag + ACC_W'(1);
          end
        end else begin
          // The returned row is row y; its bit x is the mirror of pair (x, y).
          if (rx[tag_y]) begin
            if (row_m[tag_x]) begin
              asym <= 1'b0;
              if (tag_x != tag_y) begin
                acc_conf <= acc_conf + ACC_W'(1);
              end
            end else begin
              acc_mirror <= acc_mirror + ACC_W'(1);
            end
          end
          reach <= reach_next;
          if (tag_last) begin
            pop_vec <= reach_next & ~rx;
          end
        end
      end
      if (cnt_valid) begin
        acc_trans <= acc_trans + {{(ACC_W - POP_W){1'b0}}, pop_cnt};
      end
    end
    pop_cnt <= popcount(pop_vec);
  end

  // Result registers, loaded while the pipeline drains; done is set once it has drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_DRAIN) && !tag_valid && !pop_valid && !cnt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DRAIN) begin
      is_reflexive       <= (acc_diag == '0);
      is_irreflexive     <= !diag_seen;
      is_symmetric       <= (acc_mirror == '0);
      is_antisymmetric   <= (acc_conf == '0);
      is_asymmetric      <= asym;
      is_transitive      <= (acc_trans == '0);
      is_equivalence     <= (acc_diag == '0) && (acc_mirror == '0) && (acc_trans == '0);
      is_partial_order   <= (acc_diag == '0) && (acc_conf == '0) && (acc_trans == '0);
      missing_diagonal   <= (acc_diag > ACC_W'(31)) ? 5'd31 : acc_diag[4:0];
      missing_mirror     <= (acc_mirror > ACC_W'(255)) ? 8'd255 : acc_mirror[7:0];
      antisym_conflicts  <= (acc_conf > ACC_W'(255)) ? 8'd255 : acc_conf[7:0];
      missing_transitive <= (acc_trans > ACC_W'(511)) ? 9'd511 : acc_trans[8:0];
    end
  end

endmodule

/* rtl/rpc_checker.sv */
// Port-level assertions for the relation property checker, bound to the top.
// Depends on rpc_pkg and relation_property_checker_unit_macros.svh.
`include "relation_property_checker_unit_macros.svh"

module rpc_checker
  import rpc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic [1:0] action,
  input logic       busy,
  input logic       done,
  input logic       is_reflexive,
  input logic       is_symmetric,
  input logic       is_antisymmetric,
  input logic       is_transitive,
  input logic       is_equivalence,
  input logic       is_partial_order,
  input logic [4:0] missing_diagonal,
  input logic [7:0] missing_mirror
);

  // An evaluation always passes through the drain state, so results never come back to back.
  `RPC_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  // A clear completes at its transfer and leaves the block free.
  `RPC_ASSERT_NEXT(a_clear_free, clk, rst, start && !busy && (action == ACT_CLEAR), !busy)
  // Derived flags must agree with the counts and base flags of the same result.
  `RPC_ASSERT_NOW(a_refl_count, clk, rst, done, is_reflexive == (missing_diagonal == 5'd0))
  `RPC_ASSERT_NOW(a_sym_count, clk, rst, done, is_symmetric == (missing_mirror == 8'd0))
  `RPC_ASSERT_NOW(a_compound, clk, rst, done,
                  (is_equivalence == (is_reflexive && is_symmetric && is_transitive)) &&
                  (is_partial_order == (is_reflexive && is_antisymmetric && is_transitive)))

endmodule

bind relation_property_checker_unit rpc_checker u_rpc_checker (.*);

/* verif/relation_property_checker_unit_test.sv */
// Self-checking testbench for relation_property_checker_unit: directed and
// random clear/set/evaluate commands, checked against an in-bench predictor.
// Depends on rpc_pkg and the relation_property_checker_unit RTL.
module relation_property_checker_unit_test;
  import rpc_pkg::*;

  localparam int MATRIX_DIM = 16;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TARGET_ITEMS = 1250;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] act;
    logic [3:0] row;
    logic [3:0] col;
  } command_t;

  typedef struct packed {
    logic       refl;
    logic       irrefl;
    logic       sym;
    logic       antisym;
    logic       asym;
    logic       trans;
    logic       equiv;
    logic       porder;
    logic [4:0] miss_diag;
    logic [7:0] miss_mirror;
    logic [7:0] conflicts;
    logic [8:0] miss_trans;
  } verdict_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [4:0] cfg_wdata;
  logic       start;
  logic [1:0] action;
  logic [3:0] row_index;
  logic [3:0] col_index;
  logic       busy;
  logic       done;
  logic       is_reflexive;
  logic       is_irreflexive;
  logic       is_symmetric;
  logic       is_antisymmetric;
  logic       is_asymmetric;
  logic       is_transitive;
  logic       is_equivalence;
  logic       is_partial_order;
  logic [4:0] missing_diagonal;
  logic [7:0] missing_mirror;
  logic [7:0] antisym_conflicts;
  logic [8:0] missing_transitive;

  relation_property_checker_unit #(
    .MAX_ELEMENTS(MATRIX_DIM)
  ) u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .start             (start),
    .action            (action),
    .row_index         (row_index),
    .col_index         (col_index),
    .busy              (busy),
    .done              (done),
    .is_reflexive      (is_reflexive),
    .is_irreflexive    (is_irreflexive),
    .is_symmetric      (is_symmetric),
    .is_antisymmetric  (is_antisymmetric),
    .is_asymmetric     (is_asymmetric),
    .is_transitive     (is_transitive),
    .is_equivalence    (is_equivalence),
    .is_partial_order  (is_partial_order),
    .missing_diagonal  (missing_diagonal),
    .missing_mirror    (missing_mirror),
    .antisym_conflicts (antisym_conflicts),
    .missing_transitive(missing_transitive)
  );

  // Predicted block state.
  logic [MATRIX_DIM-1:0] rel_rows [MATRIX_DIM];
  logic [4:0]            elem_count;

  command_t cmd_q[$];
  verdict_t verdict_q[$];
  command_t cur_cmd;
  int       gap_left;
  bit       gaps_on;
  int       useful_items;
  int       mismatch_count = 0;
  int       cycle_count = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int active_size();
    return (elem_count > MATRIX_DIM) ? MATRIX_DIM : int'(elem_count);
  endfunction

  function automatic verdict_t evaluate_relation();
    verdict_t              v;
    int                    n, md, mm, cf, mt, dp;
    logic [MATRIX_DIM-1:0] mask, rx, reach;
    bit                    asym;
    n = active_size();
    mask = '0;
    for (int i = 0; i < n; i++) mask[i] = 1'b1;
    md = 0; mm = 0; cf = 0; mt = 0; dp = 0;
    asym = 1'b1;
    for (int x = 0; x < n; x++) begin
      rx = rel_rows[x] & mask;
      reach = '0;
      if (rel_rows[x][x]) dp++;
      else md++;
      for (int y = 0; y < n; y++) begin
        if (rx[y]) begin
          if (rel_rows[y][x]) begin
            asym = 1'b0;
            if (x != y) cf++;
          end else begin
            mm++;
          end
          reach |= rel_rows[y] & mask;
        end
      end
      mt += $countones(reach & ~rx);
    end
    v.refl        = (md == 0);
    v.irrefl      = (dp == 0);
    v.sym         = (mm == 0);
    v.antisym     = (cf == 0);
    v.asym        = asym;
    v.trans       = (mt == 0);
    v.equiv       = v.refl && v.sym && v.trans;
    v.porder      = v.refl && v.antisym && v.trans;
    v.miss_diag   = 5'(md);
    v.miss_mirror = 8'(mm);
    v.conflicts   = 8'(cf);
    v.miss_trans  = 9'(mt);
    return v;
  endfunction

  // Applies one accepted command to the predicted matrix.
  task automatic relation_step(input command_t c);
    case (c.act)
      ACT_CLEAR: begin
        for (int i = 0; i < MATRIX_DIM; i++) rel_rows[i] = '0;
      end
      ACT_SET: begin
        if (int'(c.row) < active_size() && int'(c.col) < active_size())
          rel_rows[c.row][c.col] = 1'b1;
      end
      ACT_EVAL: begin
        verdict_q.push_back(evaluate_relation());
      end
      default: begin
      end
    endcase
  endtask

  // Command driver.
  always @(posedge clk) begin : driver_proc
    logic nxt_start;
    if (rst) begin
      start     <= 1'b0;
      action    <= ACT_CLEAR;
      row_index <= 4'd0;
      col_index <= 4'd0;
      gap_left = 0;
      for (int i = 0; i < MATRIX_DIM; i++) rel_rows[i] = '0;
    end else begin
      nxt_start = start;
      if (start && !busy) begin
        relation_step(cur_cmd);
        nxt_start = 1'b0;
        if (gaps_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 4);
      end
      if (!nxt_start) begin
        if (gap_left > 0) gap_left--;
        else if (cmd_q.size() != 0) begin
          cur_cmd = cmd_q.pop_front();
          nxt_start = 1'b1;
        end
      end
      start <= nxt_start;
      if (nxt_start) begin
        action    <= cur_cmd.act;
        row_index <= cur_cmd.row;
        col_index <= cur_cmd.col;
      end else begin
        action    <= 2'($urandom_range(0, 3));
        row_index <= 4'($urandom_range(0, 15));
        col_index <= 4'($urandom_range(0, 15));
      end
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result monitor: every strobe is one transfer.
  always @(posedge clk) begin : monitor_proc
    verdict_t want, got;
    if (!rst && done) begin
      got = {is_reflexive, is_irreflexive, is_symmetric, is_antisymmetric,
             is_asymmetric, is_transitive, is_equivalence, is_partial_order,
             missing_diagonal, missing_mirror, antisym_conflicts, missing_transitive};
      if (verdict_q.size() == 0) begin
        $error("result transfer with no evaluation pending");
        mismatch_count++;
      end else begin
        want = verdict_q.pop_front();
        check_field("is_reflexive", 32'(want.refl), 32'(got.refl));
        check_field("is_irreflexive", 32'(want.irrefl), 32'(got.irrefl));
        check_field("is_symmetric", 32'(want.sym), 32'(got.sym));
        check_field("is_antisymmetric", 32'(want.antisym), 32'(got.antisym));
        check_field("is_asymmetric", 32'(want.asym), 32'(got.asym));
        check_field("is_transitive", 32'(want.trans), 32'(got.trans));
        check_field("is_equivalence", 32'(want.equiv), 32'(got.equiv));
        check_field("is_partial_order", 32'(want.porder), 32'(got.porder));
        check_field("missing_diagonal", 32'(want.miss_diag), 32'(got.miss_diag));
        check_field("missing_mirror", 32'(want.miss_mirror), 32'(got.miss_mirror));
        check_field("antisym_conflicts", 32'(want.conflicts), 32'(got.conflicts));
        check_field("missing_transitive", 32'(want.miss_trans), 32'(got.miss_trans));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[relation_property_checker_unit] ERROR");
      $finish;
    end
  end

  // Ignored commands (unused action, out-of-range pairs) do not count.
  task automatic queue_cmd(input logic [1:0] act, input int row, input int col);
    command_t c;
    c.act = act;
    c.row = 4'(row);
    c.col = 4'(col);
    cmd_q.push_back(c);
    if (act == ACT_CLEAR || act == ACT_EVAL ||
        (act == ACT_SET && row < active_size() && col < active_size()))
      useful_items++;
  endtask

  // Mostly an index in the active range, now and then any index.
  function automatic int pick_index(input int n);
    if (n == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, 15);
    return $urandom_range(0, n - 1);
  endfunction

  task automatic wait_drain();
    while (cmd_q.size() != 0 || start || verdict_q.size() != 0) @(posedge clk);
  endtask

  // A set holds busy through a read and a write back and returns nothing, so let it finish.
  task automatic wait_idle();
    wait_drain();
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_count(input int value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= 5'(value);
    elem_count = 5'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int n, kind, r, mb, cnt;
    int cls [MATRIX_DIM];
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = 5'd0;
    gaps_on   = 1'b1;
    useful_items   = 0;
    elem_count     = 5'd16;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset size, then the zero, oversized and
    // single-element sizes.
    queue_cmd(ACT_EVAL, 0, 0);
    queue_cmd(ACT_SET, 0, 15);
    queue_cmd(ACT_EVAL, 0, 0);
    queue_cmd(ACT_SET, 15, 0);
    queue_cmd(ACT_EVAL, 15, 15);
    queue_cmd(ACT_SET, 0, 0);
    queue_cmd(ACT_SET, 15, 15);
    queue_cmd(ACT_EVAL, 0, 0);
    queue_cmd(ACT_UNUSED, 15, 15);
    queue_cmd(ACT_CLEAR, 15, 15);
    queue_cmd(ACT_EVAL, 0, 0);
    write_count(0);
    queue_cmd(ACT_EVAL, 0, 0);
    queue_cmd(ACT_SET, 0, 0);
    queue_cmd(ACT_EVAL, 0, 0);
    write_count(31);
    queue_cmd(ACT_SET, 15, 15);
    queue_cmd(ACT_EVAL, 0, 0);
    write_count(1);
    queue_cmd(ACT_SET, 1, 0);
    queue_cmd(ACT_SET, 0, 0);
    queue_cmd(ACT_EVAL, 0, 0);
    write_count(16);
    queue_cmd(ACT_EVAL, 0, 0);

    // Random phases: mostly small sets built as well-known relation shapes,
    // sometimes left uncleared so pairs from an earlier size carry over.
    while (useful_items < TARGET_ITEMS) begin
      if (useful_items >= TARGET_ITEMS - 200) gaps_on = 1'b0;
      r = $urandom_range(0, 19);
      if (r < 12) cnt = 1 + r % 6;
      else if (r < 16) cnt = $urandom_range(7, 12);
      else if (r < 18) cnt = 16;
      else if (r == 18) cnt = 0;
      else cnt = $urandom_range(17, 31);
      write_count(cnt);
      n = active_size();
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 3) != 0) queue_cmd(ACT_CLEAR, pick_index(n), pick_index(n));
        kind = $urandom_range(0, 6);
        if (n > 8 && (kind == 1 || kind == 5)) kind = 0;
        case (kind)
          0: begin
            repeat ($urandom_range(1, 2 * n + 2))
              queue_cmd(ACT_SET, pick_index(n), pick_index(n));
          end
          1: begin
            // Equivalence: all pairs within randomly drawn classes.
            for (int i = 0; i < n; i++) cls[i] = $urandom_range(0, n / 2);
            for (int i = 0; i < n; i++)
              for (int j = 0; j < n; j++)
                if (cls[i] == cls[j]) queue_cmd(ACT_SET, i, j);
          end
          2: begin
            // Partial order: subset order on index bits after a relabeling.
            mb = $urandom_range(0, 15);
            for (int i = 0; i < n; i++)
              for (int j = 0; j < n; j++)
                if ((((i ^ mb) & (j ^ mb)) == (i ^ mb)) &&
                    (i ^ mb) < n && (j ^ mb) < n)
                  queue_cmd(ACT_SET, i ^ mb, j ^ mb);
          end
          3: begin
            // Strict order in either direction.
            mb = $urandom_range(0, 1);
            for (int i = 0; i < n; i++)
              for (int j = 0; j < n; j++)
                if (mb ? (i < j) : (i > j)) queue_cmd(ACT_SET, i, j);
          end
          4: begin
            for (int i = 0; i < n; i++) queue_cmd(ACT_SET, i, i);
          end
          5: begin
            for (int i = 0; i < n; i++)
              for (int j = 0; j < n; j++) queue_cmd(ACT_SET, i, j);
          end
          default: begin
            repeat ($urandom_range(1, n + 1)) begin
              r = pick_index(n);
              mb = pick_index(n);
              queue_cmd(ACT_SET, r, mb);
              queue_cmd(ACT_SET, mb, r);
            end
          end
        endcase
        // An extra stray pair often breaks the shape just built.
        if ($urandom_range(0, 2) == 0) queue_cmd(ACT_SET, pick_index(n), pick_index(n));
        if ($urandom_range(0, 7) == 0) queue_cmd(ACT_UNUSED, pick_index(n), pick_index(n));
        queue_cmd(ACT_EVAL, pick_index(n), pick_index(n));
        if ($urandom_range(0, 3) == 0) wait_drain();
      end
    end

    wait_drain();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[relation_property_checker_unit] OK");
    end else begin
      $display("[relation_property_checker_unit] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/rpc_pkg.sv
rtl/rpc_row_store.sv
rtl/relation_property_checker_unit.sv
rtl/rpc_checker.sv
verif/relation_property_checker_unit_test.sv
